### rtl/sort_into_snake_matrix_macros.svh
// Assertion macros for the snake matrix sorter.
`ifndef SORT_INTO_SNAKE_MATRIX_MACROS_SVH
`define SORT_INTO_SNAKE_MATRIX_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SISM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sort_into_snake_matrix: assertion failed");
// Next-cycle implication.
`define SISM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sort_into_snake_matrix: assertion failed");
`else
`define SISM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SISM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/sism_pkg.sv
// Types and constants shared by the snake matrix sorter.
package sism_pkg;

    localparam int VAL_W     = 16;
    localparam int DIM_W     = 4;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_KEYW,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    // one write and one read access to the value store per cycle
    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [VAL_W-1:0] wdata;
        logic                    re;
        logic [ADDR_W-1:0]       raddr;
    } mem_req_t;

endpackage

### rtl/sism_store.sv
// Value store: simple dual-port memory with registered read data.
module sism_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                             aclk,
    input  sism_pkg::mem_req_t               req,
    output logic signed [sism_pkg::VAL_W-1:0] rd_data
);

    logic signed [sism_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [sism_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sort_into_snake_matrix.sv
// Snake matrix sorter: load, in-place insertion sort, snake-order emit.
// Load: one word per cycle, s_ready high only while loading a set.
// Sort: in-place insertion sort of n = rows*cols words (skipped when n = 1), one shift per cycle;
//   the emit phase follows the sort, or follows the load directly when n = 1.
// Emit: n result words at one per cycle while m_ready holds; the store's read register is the output stage.
// Reset (aresetn low, synchronous): rows = cols = max, load count 0; store not cleared.
module sort_into_snake_matrix #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sism_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sism_pkg::DIM_W-1:0]            cfg_data,
    // matrix elements in
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sism_pkg::VAL_W-1:0]     s_value,
    // sorted snake matrix out
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sism_pkg::IDX_W-1:0]            m_row,
    output logic [sism_pkg::IDX_W-1:0]            m_col,
    output logic signed [sism_pkg::VAL_W-1:0]     m_element,
    output logic                                  m_final_res
);

`include "sort_into_snake_matrix_macros.svh"

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [sism_pkg::DIM_W-1:0] MAX_R = sism_pkg::DIM_W'(MAX_ROWS);
    localparam logic [sism_pkg::DIM_W-1:0] MAX_C = sism_pkg::DIM_W'(MAX_COLS);

    sism_pkg::state_t state_reg, state_next;

    logic [sism_pkg::DIM_W-1:0]        rows_reg, cols_reg;
    logic [CNT_W-1:0]                  load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]                  i_reg, i_next;   // element being inserted
    logic [CNT_W-1:0]                  j_reg, j_next;   // hole position
    logic signed [sism_pkg::VAL_W-1:0] key_reg, key_next;
    logic [sism_pkg::IDX_W-1:0]        r_reg, r_next, c_reg, c_next;
    logic                              m_valid_reg, m_valid_next;
    logic [sism_pkg::IDX_W-1:0]        m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic                              m_final_reg, m_final_next;

    sism_pkg::mem_req_t                mem_req;
    logic signed [sism_pkg::VAL_W-1:0] rd_data;

    // effective dimensions, out-of-range values clamped
    logic [sism_pkg::DIM_W-1:0]        nr, nc;
    logic [CNT_W-1:0]                  total;
    logic [CNT_W-1:0]                  load_cnt_inc, i_inc;
    // snake addressing for the emit phase
    logic [sism_pkg::DIM_W-1:0]        pos;
    logic [2*sism_pkg::DIM_W-1:0]      emit_addr;
    logic                              col_last, row_last;

    always_comb begin
        nr = (rows_reg == '0) ? 4'd1 : ((rows_reg > MAX_R) ? MAX_R : rows_reg);
        nc = (cols_reg == '0) ? 4'd1 : ((cols_reg > MAX_C) ? MAX_C : cols_reg);
    end

    assign total        = CNT_W'({4'd0, nr} * {4'd0, nc});
    assign load_cnt_inc = load_cnt_reg + 1'b1;
    assign i_inc        = i_reg + 1'b1;

    // odd rows run right to left through the sorted list
    assign pos       = r_reg[0] ? (nc - 4'd1 - {1'b0, c_reg}) : {1'b0, c_reg};
    assign emit_addr = ({5'd0, r_reg} * {4'd0, nc}) + {4'd0, pos};
    assign col_last  = ({1'b0, c_reg} == (nc - 4'd1));
    assign row_last  = ({1'b0, r_reg} == (nr - 4'd1));

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= MAX_R;
            cols_reg <= MAX_C;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                sism_pkg::CFG_ROWS: rows_reg <= cfg_data;
                sism_pkg::CFG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sism_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        m_row_reg   <= m_row_next;
        m_col_reg   <= m_col_next;
        m_final_reg <= m_final_next;
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        r_next        = '0;
        c_next        = '0;
        m_valid_next  = m_valid_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_final_next  = m_final_reg;
        mem_req       = '0;

        case (state_reg)
            sism_pkg::ST_LOAD: begin
                if (s_valid) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = sism_pkg::ADDR_W'(load_cnt_reg[AW-1:0]);
                    mem_req.wdata = s_value;
                    if (load_cnt_inc >= total) begin
                        load_cnt_next = '0;
                        i_next        = CNT_W'(1);
                        state_next    = (total == CNT_W'(1)) ? sism_pkg::ST_EMIT
                                                             : sism_pkg::ST_KEY;
                    end else begin
                        load_cnt_next = load_cnt_inc;
                    end
                end
            end

            sism_pkg::ST_KEY: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = sism_pkg::ADDR_W'(i_reg);
                state_next    = sism_pkg::ST_KEYW;
            end

            // key arrives; fetch its left neighbor
            sism_pkg::ST_KEYW: begin
                key_next      = rd_data;
                j_next        = i_reg;
                mem_req.re    = 1'b1;
                mem_req.raddr = sism_pkg::ADDR_W'(i_reg - 1'b1);
                state_next    = sism_pkg::ST_SCAN;
            end

            // rd_data holds a[j-1]; shift it right or drop the key in the hole
            sism_pkg::ST_SCAN: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sism_pkg::ADDR_W'(j_reg);
                if (rd_data > key_reg) begin
                    mem_req.wdata = rd_data;
                    j_next        = j_reg - 1'b1;
                    if (j_reg > CNT_W'(1)) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = sism_pkg::ADDR_W'(j_reg - CNT_W'(2));
                    end else begin
                        state_next = sism_pkg::ST_PLACE;
                    end
                end else begin
                    mem_req.wdata = key_reg;
                    i_next        = i_inc;
                    if (i_inc < total) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = sism_pkg::ADDR_W'(i_inc);
                        state_next    = sism_pkg::ST_KEYW;
                    end else begin
                        state_next = sism_pkg::ST_EMIT;
                    end
                end
            end

            // key belongs in slot 0
            sism_pkg::ST_PLACE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sism_pkg::ADDR_W'(j_reg);
                mem_req.wdata = key_reg;
                i_next        = i_inc;
                if (i_inc < total) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sism_pkg::ADDR_W'(i_inc);
                    state_next    = sism_pkg::ST_KEYW;
                end else begin
                    state_next = sism_pkg::ST_EMIT;
                end
            end

            // read register doubles as output stage: refill when empty or taken
            sism_pkg::ST_EMIT: begin
                r_next = r_reg;
                c_next = c_reg;
                if (!m_valid_reg || m_ready) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sism_pkg::ADDR_W'(emit_addr[AW-1:0]);
                    m_valid_next  = 1'b1;
                    m_row_next    = r_reg;
                    m_col_next    = c_reg;
                    m_final_next  = col_last && row_last;
                    if (col_last && row_last) begin
                        state_next = sism_pkg::ST_DRAIN;
                    end else if (col_last) begin
                        c_next = '0;
                        r_next = r_reg + 1'b1;
                    end else begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end

            sism_pkg::ST_DRAIN: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = sism_pkg::ST_LOAD;
                end
            end

            default: begin
                state_next = sism_pkg::ST_LOAD;
            end
        endcase
    end

    sism_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign s_ready     = (state_reg == sism_pkg::ST_LOAD);
    assign m_valid     = m_valid_reg;
    assign m_row       = m_row_reg;
    assign m_col       = m_col_reg;
    assign m_element   = rd_data;
    assign m_final_res = m_final_reg;

    // loading and emitting never overlap
    `SISM_ASSERT_IMP(a_load_emit_excl, aclk, aresetn, s_ready, !m_valid)
    // sort and emit never read an entry in the cycle it is rewritten
    `SISM_ASSERT_IMP(a_no_rw_collide, aclk, aresetn, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr)
    // taking the last word of a set reopens the input
    `SISM_ASSERT_NXT(a_final_ends_set, aclk, aresetn, m_valid && m_ready && m_final_res, s_ready)
    // load count stays inside the store
    `SISM_ASSERT_IMP(a_cnt_in_range, aclk, aresetn, s_ready, load_cnt_reg < CNT_W'(DEPTH))

endmodule
